// ----- rtl/core/dfmr_pkg.sv -----
package dfmr_pkg;

  localparam int SwW       = 18;
  localparam int DstW      = 23;
  localparam int PortW     = 7;
  localparam int AW        = 7;
  localparam int HW        = 6;
  localparam int PW        = 6;
  localparam int ApW       = 13;
  localparam int GrpW      = 13;
  localparam int LocW      = 7;
  localparam int PortCalcW = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 7;

  localparam logic [AW-1:0]        ResetA      = 7'd4;
  localparam logic [HW-1:0]        ResetH      = 6'd2;
  localparam logic [PW-1:0]        ResetP      = 6'd2;
  localparam logic [ApW-1:0]       ResetAp     = ApW'(int'(ResetA) * int'(ResetP));
  localparam logic [GrpW-1:0]      ResetGroups = GrpW'(int'(ResetA) * int'(ResetH) + 1);
  localparam logic [PortCalcW-1:0] PortMax     = 8'd127;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIdxA = 2'd0,
    CfgIdxH = 2'd1,
    CfgIdxP = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SwW-1:0]  switch_id;
    logic [DstW-1:0] dest_port;
  } in_word_t;

  typedef struct packed {
    logic [PortW-1:0] out_port;
    logic             range_error;
  } out_word_t;

  typedef struct packed {
    logic [AW-1:0]   a;
    logic [HW-1:0]   h;
    logic [PW-1:0]   p;
    logic [ApW-1:0]  ap;
    logic [GrpW-1:0] groups;
  } topo_t;

endpackage

// ----- rtl/core/dfmr_cfg.sv -----
module dfmr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dfmr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dfmr_pkg::CfgDataW-1:0] cfg_data_i,
  output dfmr_pkg::topo_t               topo_o
);
  import dfmr_pkg::*;

  logic [AW-1:0]   a_q, a_d;
  logic [HW-1:0]   h_q, h_d;
  logic [PW-1:0]   p_q, p_d;
  logic [ApW-1:0]  ap_q, ap_d;
  logic [GrpW-1:0] groups_q, groups_d;

  always_comb begin
    a_d = a_q;
    h_d = h_q;
    p_d = p_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgIdxA: a_d = cfg_data_i[AW-1:0];
        CfgIdxH: h_d = cfg_data_i[HW-1:0];
        CfgIdxP: p_d = cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // derived topology values, one register after each product
  assign ap_d     = ApW'(a_d) * ApW'(p_d);
  assign groups_d = GrpW'(a_d) * GrpW'(h_d) + GrpW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q      <= ResetA;
      h_q      <= ResetH;
      p_q      <= ResetP;
      ap_q     <= ResetAp;
      groups_q <= ResetGroups;
    end else begin
      a_q      <= a_d;
      h_q      <= h_d;
      p_q      <= p_d;
      ap_q     <= ap_d;
      groups_q <= groups_d;
    end
  end

  assign topo_o.a      = a_q;
  assign topo_o.h      = h_q;
  assign topo_o.p      = p_q;
  assign topo_o.ap     = ap_q;
  assign topo_o.groups = groups_q;

endmodule

// ----- rtl/core/dfmr_skid.sv -----
module dfmr_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dfmr_pkg::in_word_t in_word_i,
  input  logic               adv_i,
  output logic               ent_valid_o,
  output dfmr_pkg::in_word_t ent_word_o
);
  import dfmr_pkg::*;

  logic     skid_vld_q, skid_vld_d;
  in_word_t skid_q;
  logic     acc;

  assign in_stall_o  = skid_vld_q;
  assign acc         = in_valid_i && !skid_vld_q;
  assign ent_valid_o = skid_vld_q || in_valid_i;
  assign ent_word_o  = skid_vld_q ? skid_q : in_word_i;
  assign skid_vld_d  = adv_i ? 1'b0 : (skid_vld_q || acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv_i && acc) begin
      skid_q <= in_word_i;
    end
  end

`ifndef SYNTH
  a_fill_only_when_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(!adv_i))
    else $error("skid filled while pipeline advanced");
  a_fill_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(in_valid_i))
    else $error("skid filled without a word");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && adv_i |=> !skid_vld_q)
    else $error("skid not drained on advance");
`endif

endmodule

// ----- rtl/core/dfmr_route.sv -----
module dfmr_route (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ent_valid_i,
  input  dfmr_pkg::in_word_t  ent_word_i,
  input  dfmr_pkg::topo_t     topo_i,
  input  logic                out_stall_i,
  output logic                adv_o,
  output logic                out_valid_o,
  output dfmr_pkg::out_word_t out_word_o
);
  import dfmr_pkg::*;

  localparam int Q1      = GrpW;
  localparam int Q2      = LocW;
  localparam int NStg    = Q1 + Q2 + 3;
  localparam int SwCmpW  = AW + Q1;
  localparam int DstCmpW = ApW + Q1;
  localparam int RdCmpW  = PW + Q2;
  localparam int KCmpW   = HW + Q2;

  typedef struct packed {
    logic [SwW-1:0]  sw_rem;
    logic [GrpW-1:0] sw_quo;
    logic [DstW-1:0] dst_rem;
    logic [GrpW-1:0] dst_quo;
  } p1_t;

  typedef struct packed {
    logic            err;
    logic            same;
    logic [LocW-1:0] r_src;
    logic [ApW-1:0]  rd_rem;
    logic [LocW-1:0] rd_quo;
    logic [GrpW-1:0] k_rem;
    logic [LocW-1:0] k_quo;
  } p2_t;

  logic [NStg-1:0] vld_q;
  p1_t             p1_q [Q1+1];
  p2_t             p2_q [Q2+1];
  out_word_t       out_q;

  assign adv_o = !(vld_q[NStg-1] && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_o) begin
      vld_q <= {vld_q[NStg-2:0], ent_valid_i};
    end
  end

  // group and in-group position of switch and destination
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      p1_q[0].sw_rem  <= ent_word_i.switch_id;
      p1_q[0].sw_quo  <= '0;
      p1_q[0].dst_rem <= ent_word_i.dest_port;
      p1_q[0].dst_quo <= '0;
    end
  end

  for (genvar i = 0; i < Q1; i++) begin : g_div1
    localparam int Sh = Q1 - 1 - i;
    logic [SwCmpW-1:0]  sw_dvs;
    logic [DstCmpW-1:0] dst_dvs;
    logic               sw_ge;
    logic               dst_ge;
    p1_t                nxt;

    assign sw_dvs  = SwCmpW'(topo_i.a) << Sh;
    assign dst_dvs = DstCmpW'(topo_i.ap) << Sh;
    assign sw_ge   = SwCmpW'(p1_q[i].sw_rem) >= sw_dvs;
    assign dst_ge  = DstCmpW'(p1_q[i].dst_rem) >= dst_dvs;

    always_comb begin
      nxt = p1_q[i];
      if (sw_ge) begin
        nxt.sw_rem     = p1_q[i].sw_rem - sw_dvs[SwW-1:0];
        nxt.sw_quo[Sh] = 1'b1;
      end
      if (dst_ge) begin
        nxt.dst_rem     = p1_q[i].dst_rem - dst_dvs[DstW-1:0];
        nxt.dst_quo[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_o) begin
        p1_q[i+1] <= nxt;
      end
    end
  end

  // range check and global link index
  logic [GrpW-1:0] g_src, g_dst;

  assign g_src = p1_q[Q1].sw_quo;
  assign g_dst = p1_q[Q1].dst_quo;

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      p2_q[0].err    <= (g_src >= topo_i.groups) || (g_dst >= topo_i.groups);
      p2_q[0].same   <= g_src == g_dst;
      p2_q[0].r_src  <= p1_q[Q1].sw_rem[LocW-1:0];
      p2_q[0].rd_rem <= p1_q[Q1].dst_rem[ApW-1:0];
      p2_q[0].rd_quo <= '0;
      p2_q[0].k_rem  <= (g_dst > g_src) ? g_dst - GrpW'(1) : g_dst;
      p2_q[0].k_quo  <= '0;
    end
  end

  for (genvar i = 0; i < Q2; i++) begin : g_div2
    localparam int Sh = Q2 - 1 - i;
    logic [RdCmpW-1:0] rd_dvs;
    logic [KCmpW-1:0]  k_dvs;
    logic              rd_ge;
    logic              k_ge;
    p2_t               nxt;

    assign rd_dvs = RdCmpW'(topo_i.p) << Sh;
    assign k_dvs  = KCmpW'(topo_i.h) << Sh;
    assign rd_ge  = RdCmpW'(p2_q[i].rd_rem) >= rd_dvs;
    assign k_ge   = KCmpW'(p2_q[i].k_rem) >= k_dvs;

    always_comb begin
      nxt = p2_q[i];
      if (rd_ge) begin
        nxt.rd_rem     = p2_q[i].rd_rem - rd_dvs[ApW-1:0];
        nxt.rd_quo[Sh] = 1'b1;
      end
      if (k_ge) begin
        nxt.k_rem     = p2_q[i].k_rem - k_dvs[GrpW-1:0];
        nxt.k_quo[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_o) begin
        p2_q[i+1] <= nxt;
      end
    end
  end

  // port selection
  logic [PortCalcW-1:0] base, rs, rd, gw, slot, dmod, port;
  logic                 err_all;

  assign base = PortCalcW'(topo_i.p) + PortCalcW'(topo_i.h);
  assign rs   = PortCalcW'(p2_q[Q2].r_src);
  assign rd   = PortCalcW'(p2_q[Q2].rd_quo);
  assign gw   = PortCalcW'(p2_q[Q2].k_quo);
  assign slot = PortCalcW'(p2_q[Q2].k_rem[HW-1:0]);
  assign dmod = PortCalcW'(p2_q[Q2].rd_rem[PW-1:0]);

  always_comb begin
    if (!p2_q[Q2].same) begin
      if (rs == gw) begin
        port = PortCalcW'(topo_i.p) + slot;
      end else if (rs < gw) begin
        port = base + gw - PortCalcW'(1);
      end else begin
        port = base + gw;
      end
    end else if (rd > rs) begin
      port = base + rd - PortCalcW'(1);
    end else if (rd < rs) begin
      port = base + rd;
    end else begin
      port = dmod;
    end
  end

  assign err_all = p2_q[Q2].err || (port > PortMax);

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      out_q.range_error <= err_all;
      out_q.out_port    <= err_all ? '0 : port[PortW-1:0];
    end
  end

  assign out_valid_o = vld_q[NStg-1];
  assign out_word_o  = out_q;

`ifndef SYNTH
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_o |=> $stable(vld_q))
    else $error("pipeline moved while frozen");
  a_err_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NStg-2] && adv_o && err_all |=> out_valid_o && out_word_o.out_port == '0)
    else $error("flagged word carries a port");
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_o && vld_q[NStg-2] |=> out_valid_o)
    else $error("word lost at output stage");
`endif

endmodule

// ----- rtl/core/dragonfly_minimal_route_port_core.sv -----
// throughput: one word per cycle while no output stall holds the pipeline, which has
// 23 register stages; an output stall while the last stage holds a valid word freezes
// the whole pipeline; a word arriving then waits in an input skid register and input
// stall stays high until the first advancing edge moves it on
// reset: topology registers return to 4 switches, 2 global links, 2 hosts; pipeline empties
module dragonfly_minimal_route_port_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dfmr_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dfmr_pkg::out_word_t           out_word_o,
  input  logic                          cfg_we_i,
  input  logic [dfmr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dfmr_pkg::CfgDataW-1:0] cfg_data_i
);
  import dfmr_pkg::*;

  topo_t    topo;
  logic     adv;
  logic     ent_valid;
  in_word_t ent_word;

  dfmr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .topo_o     (topo)
  );

  dfmr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .adv_i       (adv),
    .ent_valid_o (ent_valid),
    .ent_word_o  (ent_word)
  );

  dfmr_route u_route (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (ent_valid),
    .ent_word_i  (ent_word),
    .topo_i      (topo),
    .out_stall_i (out_stall_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- tb/dragonfly_minimal_route_port_core_tb.sv -----
`timescale 1ns / 1ps

module dragonfly_minimal_route_port_core_tb;
  import dfmr_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 40;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_word_t in_word_i;
  logic out_valid_o;
  logic out_stall_i;
  out_word_t out_word_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  logic [AW-1:0] topo_a = ResetA;
  logic [HW-1:0] topo_h = ResetH;
  logic [PW-1:0] topo_p = ResetP;

  in_word_t header_q[$];
  out_word_t exp_routes_q[$];

  bit in_taken = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned words_in = 0;
  int unsigned words_flagged = 0;
  int unsigned topo_settings = 0;

  dragonfly_minimal_route_port_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_word_t route_port(in_word_t w);
    longint unsigned a, h, p, sw, dst, grp, ap, gs, rs, gd, rd, k, gw, port;
    out_word_t r;
    a = topo_a;
    h = topo_h;
    p = topo_p;
    sw = w.switch_id;
    dst = w.dest_port;
    grp = a * h + 1;
    r.out_port = '0;
    r.range_error = 1'b1;
    if (sw >= a * grp || dst >= a * p * grp) return r;
    ap = a * p;
    gs = sw / a;
    rs = sw % a;
    gd = dst / ap;
    rd = (dst % ap) / p;
    if (gd != gs) begin
      k = (gd > gs) ? gd - 1 : gd;
      gw = k / h;
      if (rs == gw) port = p + (k % h);
      else if (rs < gw) port = p + h + gw - 1;
      else port = p + h + gw;
    end else if (rd > rs) begin
      port = p + h + rd - 1;
    end else if (rd < rs) begin
      port = p + h + rd;
    end else begin
      port = dst % p;
    end
    if (port > PortMax) return r;
    r.out_port = PortW'(port);
    r.range_error = 1'b0;
    return r;
  endfunction

  function automatic in_word_t gen_header();
    longint unsigned a, h, p, nsw, nhost, cap_sw, cap_dst, sw, dst, gs, rs, k, gd;
    int unsigned pick;
    in_word_t w;
    a = topo_a;
    h = topo_h;
    p = topo_p;
    nsw = a * (a * h + 1);
    nhost = nsw * p;
    cap_sw = (nsw < (64'd1 << SwW)) ? nsw : (64'd1 << SwW);
    cap_dst = (nhost < (64'd1 << DstW)) ? nhost : (64'd1 << DstW);
    pick = $urandom_range(0, 99);
    w.switch_id = SwW'($urandom());
    w.dest_port = DstW'($urandom());
    if (pick < 8 || nsw == 0 || nhost == 0) return w;
    sw = $urandom_range(0, cap_sw - 1);
    dst = $urandom_range(0, cap_dst - 1);
    if (pick < 14 && cap_sw == nsw && nsw < (64'd1 << SwW)) begin
      sw = $urandom_range(nsw, (1 << SwW) - 1);
    end else if (pick < 18 && nhost < (64'd1 << DstW)) begin
      dst = $urandom_range(nhost, (1 << DstW) - 1);
    end else if (pick < 45) begin
      dst = sw * p + $urandom_range(0, p - 1);
    end else if (pick < 65) begin
      dst = (sw / a) * a * p + $urandom_range(0, a * p - 1);
    end else if (pick < 85 && h != 0) begin
      gs = sw / a;
      rs = sw % a;
      k = rs * h + $urandom_range(0, h - 1);
      gd = (k >= gs) ? k + 1 : k;
      dst = gd * a * p + $urandom_range(0, a * p - 1);
    end
    if (dst >= cap_dst && pick >= 18) dst = $urandom_range(0, cap_dst - 1);
    w.switch_id = SwW'(sw);
    w.dest_port = DstW'(dst);
    return w;
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic queue_header(input longint unsigned sw, input longint unsigned dst);
    in_word_t w;
    w.switch_id = SwW'(sw);
    w.dest_port = DstW'(dst);
    header_q.insert(header_q.size(), w);
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) header_q.insert(header_q.size(), gen_header());
  endtask

  task automatic wait_idle();
    while (header_q.size() != 0 || in_valid_i || exp_routes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgIdxA: topo_a = val;
      CfgIdxH: topo_h = val[HW-1:0];
      CfgIdxP: topo_p = val[PW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_topo(input logic [CfgDataW-1:0] a, input logic [CfgDataW-1:0] h,
                          input logic [CfgDataW-1:0] p);
    wait_idle();
    write_reg(CfgIdxA, a);
    write_reg(CfgIdxH, h);
    write_reg(CfgIdxP, p);
    topo_settings++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin : accept
    out_word_t route;
    in_taken = rst_ni && in_valid_i && (in_stall_o === 1'b0);
    if (in_taken) begin
      route = route_port(in_word_i);
      exp_routes_q.insert(exp_routes_q.size(), route);
      words_in++;
      if (route.range_error) words_flagged++;
    end
  end

  always @(negedge clk_i) begin : drive
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (header_q.size() > 0) begin
        in_word_i <= header_q[0];
        header_q.delete(0);
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : back_pressure
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!out_calm && $urandom_range(0, 99) < 20) begin
      stall_left = pick_gap(1'b0);
      out_stall_i <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check
    out_word_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (exp_routes_q.size() == 0) begin
        note_failure($sformatf("unexpected word port=%0d err=%0b",
                               out_word_o.out_port, out_word_o.range_error));
      end else begin
        want = exp_routes_q[0];
        exp_routes_q.delete(0);
        if (out_word_o.out_port !== want.out_port ||
            out_word_o.range_error !== want.range_error) begin
          note_failure($sformatf("port exp %0d got %0d, err exp %0b got %0b",
                                 want.out_port, out_word_o.out_port,
                                 want.range_error, out_word_o.range_error));
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset topology: 4 switches, 2 global links, 2 hosts, 9 groups
    queue_header(0, 0);
    queue_header(0, 1);
    queue_header(0, 2);
    queue_header(3, 0);
    queue_header(0, 8);
    queue_header(0, 16);
    queue_header(1, 8);
    queue_header(0, 71);
    queue_header(35, 0);
    queue_header(12, 8);
    queue_header(35, 71);
    queue_header(36, 0);
    queue_header(0, 72);
    queue_header((1 << SwW) - 1, (1 << DstW) - 1);
    queue_header(0, (1 << DstW) - 1);
    queue_random(200);

    set_topo(1, 1, 1);
    queue_random(150);

    set_topo(64, 32, 32);
    queue_header(131135, 4196351);
    queue_header(131136, 0);
    queue_random(250);

    // empty network
    set_topo(0, 2, 2);
    queue_header(0, 0);
    queue_random(40);

    // single group
    set_topo(4, 0, 3);
    queue_header(0, 0);
    queue_header(3, 11);
    queue_random(150);

    set_topo(3, 2, 0);
    queue_header(0, 0);
    queue_random(40);

    // upper data bits dropped on the 6-bit registers, ports overflow
    set_topo(127, 127, 127);
    queue_header(126, 0);
    queue_header(0, 126 * 63);
    queue_random(150);

    repeat (6) begin
      set_topo(CfgDataW'($urandom_range(1, 64)), CfgDataW'($urandom_range(1, 32)),
               CfgDataW'($urandom_range(1, 32)));
      queue_random(60);
      wait_idle();
      write_reg(CfgIdxSpare, CfgDataW'($urandom()));
      queue_random(60);
    end

    wait_idle();
    $display("%0d words routed over %0d topology settings, %0d flagged out of range",
             words_in, topo_settings + 1, words_flagged);
    $display("%0d mismatches in %0d cycles", fail_cnt, cycle_cnt);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
